>>> design/srfs_pkg.sv
// ----------------------------------------------------------------------------
// srfs_pkg: shared types and constants of the framed register-space slave
// Holds the transfer payloads, the parser phase encoding, the status codes
// and the fixed bytes of the request and response frames.
// ----------------------------------------------------------------------------
package srfs_pkg;

    localparam logic [7:0] REQ_SYNC    = 8'hA5;
    localparam logic [7:0] RESP_SYNC   = 8'hB5;
    localparam logic [7:0] RESP_TYPE   = 8'h00;
    localparam logic [7:0] RESP_RESULT = 8'h01;
    localparam logic [7:0] ZERO_BYTE   = 8'h00;

    localparam logic [4:0] RESP_HEAD_BYTES = 5'd13;
    localparam logic [3:0] HEAD_LAST      = 4'd8;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_HUNT  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_HEAD = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_BYTE = 2'd1,
        KIND_MEM  = 2'd2,
        KIND_SUM  = 2'd3
    } kind_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } req_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       tx_last;
        logic       frame_done;
        logic [1:0] status;
    } rsp_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] tx_byte;
        logic       frame_done;
        logic [1:0] status;
        logic       clr_sum;
    } stage_t;

endpackage

>>> design/srfs_stream_if.sv
// ----------------------------------------------------------------------------
// srfs_stream_if: valid/ready channel
// Carries one payload per transfer; a transfer happens at a rising edge
// where valid and ready are both high.
// ----------------------------------------------------------------------------
interface srfs_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/spi_register_space_frame_slave.sv
// ----------------------------------------------------------------------------
// spi_register_space_frame_slave: framed register-space slave
// Parses framed read/write requests byte by byte and returns response bytes
// on pulls, backed by a byte-addressed register space.
// ----------------------------------------------------------------------------
// Every accepted request transfer yields exactly one response transfer. The
// block accepts one transfer per clock cycle unless the register-space clear
// or a stalled internal stage holds req.ready low. An accepted transfer is
// held in one internal stage; its result enters the output register when the
// stage advances, which waits while a stalled response holds the output
// register. The extra stage exists because read data comes from a single-port
// register-space memory with a registered read. After reset the block clears
// the register space, one byte per cycle, with req.ready low until it is done.
module spi_register_space_frame_slave #(
    parameter int SPACE_BYTES = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    srfs_stream_if.sink   req,
    srfs_stream_if.source rsp
);

    localparam int AW = (SPACE_BYTES > 1) ? $clog2(SPACE_BYTES) : 1;
    localparam logic [17:0] SPACE_LIM = 18'(SPACE_BYTES);
    localparam logic [AW-1:0] CLR_LAST = AW'(SPACE_BYTES - 1);

    logic [7:0] mem [SPACE_BYTES];

    srfs_pkg::phase_t phase_reg, phase_next;
    logic [3:0]       head_cnt_reg, head_cnt_next;
    logic [15:0]      seq_reg, seq_next;
    logic             is_write_reg, is_write_next;
    logic [15:0]      base_reg, base_next;
    logic [15:0]      len_reg, len_next;
    logic [15:0]      data_cnt_reg, data_cnt_next;
    logic             pending_reg, pending_next;
    logic [16:0]      cursor_reg, cursor_next;
    logic             range_err_reg, range_err_next;

    logic             clearing_reg;
    logic [AW-1:0]    clr_cnt_reg;

    logic             s1_valid_reg;
    srfs_pkg::stage_t s1_reg, s1_next;
    logic [7:0]       rdata_reg;
    logic [7:0]       sum_reg, sum_next;
    logic             out_valid_reg;
    srfs_pkg::rsp_t   out_reg, out_next;

    logic             accept;
    logic             s1_adv;
    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [7:0]       mem_wdata;

    logic [15:0]      resp_len;
    logic [16:0]      resp_end;
    logic [16:0]      rd_off;
    logic [17:0]      rd_addr;
    logic [17:0]      wr_addr;
    logic [15:0]      data_cnt_inc;
    logic [7:0]       head_byte;
    logic [7:0]       b;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !clearing_reg && (!s1_valid_reg || s1_adv);
    assign accept    = req.valid && req.ready;
    assign b         = req.data.rx_byte;

    assign resp_len     = is_write_reg ? 16'd0 : len_reg;
    assign resp_end     = 17'(srfs_pkg::RESP_HEAD_BYTES) + {1'b0, resp_len};
    assign rd_off       = cursor_reg - 17'(srfs_pkg::RESP_HEAD_BYTES);
    assign rd_addr      = {2'b00, base_reg} + {1'b0, rd_off};
    assign wr_addr      = {2'b00, base_reg} + {2'b00, data_cnt_reg};
    assign data_cnt_inc = data_cnt_reg + 16'd1;

    always_comb
    begin
        unique case (cursor_reg[3:0])
            4'd0:    head_byte = srfs_pkg::RESP_SYNC;
            4'd1:    head_byte = seq_reg[7:0];
            4'd2:    head_byte = seq_reg[15:8];
            4'd3:    head_byte = srfs_pkg::RESP_TYPE;
            4'd4:    head_byte = srfs_pkg::RESP_RESULT;
            4'd11:   head_byte = resp_len[7:0];
            4'd12:   head_byte = resp_len[15:8];
            default: head_byte = srfs_pkg::ZERO_BYTE;
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        head_cnt_next  = head_cnt_reg;
        seq_next       = seq_reg;
        is_write_next  = is_write_reg;
        base_next      = base_reg;
        len_next       = len_reg;
        data_cnt_next  = data_cnt_reg;
        pending_next   = pending_reg;
        cursor_next    = cursor_reg;
        range_err_next = range_err_reg;
        s1_next        = '{kind: srfs_pkg::KIND_NONE, tx_byte: srfs_pkg::ZERO_BYTE,
                           frame_done: 1'b0, status: srfs_pkg::ST_OK, clr_sum: 1'b0};
        mem_we         = 1'b0;
        mem_waddr      = wr_addr[AW-1:0];
        mem_wdata      = b;
        mem_re         = 1'b0;
        mem_raddr      = rd_addr[AW-1:0];

        if (clearing_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = srfs_pkg::ZERO_BYTE;
        end
        else if (accept && req.data.req_type)
        begin
            if (pending_reg)
            begin
                if (cursor_reg >= resp_end)
                begin
                    s1_next.kind = srfs_pkg::KIND_SUM;
                    pending_next = 1'b0;
                    cursor_next  = '0;
                end
                else
                begin
                    if (cursor_reg < 17'(srfs_pkg::RESP_HEAD_BYTES))
                    begin
                        s1_next.kind    = srfs_pkg::KIND_BYTE;
                        s1_next.tx_byte = head_byte;
                    end
                    else if (rd_addr < SPACE_LIM)
                    begin
                        s1_next.kind = srfs_pkg::KIND_MEM;
                        mem_re       = 1'b1;
                    end
                    else
                    begin
                        s1_next.kind = srfs_pkg::KIND_BYTE;
                    end
                    cursor_next = cursor_reg + 17'd1;
                end
            end
            if (range_err_reg)
                s1_next.status = srfs_pkg::ST_RANGE;
            else if (phase_reg == srfs_pkg::PH_HUNT)
                s1_next.status = srfs_pkg::ST_HUNT;
            else
                s1_next.status = srfs_pkg::ST_OK;
        end
        else if (accept)
        begin
            unique case (phase_reg)
                srfs_pkg::PH_HEAD:
                begin
                    unique case (head_cnt_reg)
                        4'd1:    seq_next      = {seq_reg[15:8], b};
                        4'd2:    seq_next      = {b, seq_reg[7:0]};
                        4'd4:    is_write_next = (b != 8'd0);
                        4'd5:    base_next     = {base_reg[15:8], b};
                        4'd6:    base_next     = {b, base_reg[7:0]};
                        4'd7:    len_next      = {len_reg[15:8], b};
                        4'd8:    len_next      = {b, len_reg[7:0]};
                        default: seq_next      = seq_reg;
                    endcase
                    if (head_cnt_reg >= srfs_pkg::HEAD_LAST)
                    begin
                        if (is_write_reg && (len_next != 16'd0))
                        begin
                            phase_next    = srfs_pkg::PH_DATA;
                            data_cnt_next = '0;
                        end
                        else
                        begin
                            phase_next         = srfs_pkg::PH_HUNT;
                            head_cnt_next      = '0;
                            pending_next       = 1'b1;
                            cursor_next        = '0;
                            s1_next.clr_sum    = 1'b1;
                            s1_next.frame_done = 1'b1;
                        end
                    end
                    else
                    begin
                        head_cnt_next = head_cnt_reg + 4'd1;
                    end
                end
                srfs_pkg::PH_DATA:
                begin
                    if (wr_addr < SPACE_LIM)
                        mem_we = 1'b1;
                    else
                        range_err_next = 1'b1;
                    data_cnt_next = data_cnt_inc;
                    if (data_cnt_inc >= len_reg)
                    begin
                        phase_next         = srfs_pkg::PH_HUNT;
                        head_cnt_next      = '0;
                        pending_next       = 1'b1;
                        cursor_next        = '0;
                        s1_next.clr_sum    = 1'b1;
                        s1_next.frame_done = 1'b1;
                    end
                end
                default:
                begin
                    if (b == srfs_pkg::REQ_SYNC)
                    begin
                        phase_next      = srfs_pkg::PH_HEAD;
                        head_cnt_next   = 4'd1;
                        range_err_next  = 1'b0;
                        pending_next    = 1'b0;
                        cursor_next     = '0;
                        s1_next.clr_sum = 1'b1;
                    end
                end
            endcase
            if ((phase_reg == srfs_pkg::PH_HUNT) && (b != srfs_pkg::REQ_SYNC))
                s1_next.status = srfs_pkg::ST_HUNT;
            else if (range_err_next)
                s1_next.status = srfs_pkg::ST_RANGE;
            else
                s1_next.status = srfs_pkg::ST_OK;
        end
    end

    always_comb
    begin
        out_next = '{tx_byte: srfs_pkg::ZERO_BYTE, tx_valid: 1'b0, tx_last: 1'b0,
                     frame_done: s1_reg.frame_done, status: s1_reg.status};
        sum_next = sum_reg;
        unique case (s1_reg.kind)
            srfs_pkg::KIND_BYTE:
            begin
                out_next.tx_byte  = s1_reg.tx_byte;
                out_next.tx_valid = 1'b1;
            end
            srfs_pkg::KIND_MEM:
            begin
                out_next.tx_byte  = rdata_reg;
                out_next.tx_valid = 1'b1;
            end
            srfs_pkg::KIND_SUM:
            begin
                out_next.tx_byte  = sum_reg;
                out_next.tx_valid = 1'b1;
                out_next.tx_last  = 1'b1;
            end
            default:
            begin
                out_next.tx_valid = 1'b0;
            end
        endcase
        if (s1_adv)
        begin
            if (s1_reg.clr_sum || (s1_reg.kind == srfs_pkg::KIND_SUM))
                sum_next = 8'd0;
            else
                sum_next = sum_reg ^ out_next.tx_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= srfs_pkg::PH_HUNT;
            head_cnt_reg  <= '0;
            seq_reg       <= '0;
            is_write_reg  <= 1'b0;
            base_reg      <= '0;
            len_reg       <= '0;
            data_cnt_reg  <= '0;
            pending_reg   <= 1'b0;
            cursor_reg    <= '0;
            range_err_reg <= 1'b0;
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            head_cnt_reg  <= head_cnt_next;
            seq_reg       <= seq_next;
            is_write_reg  <= is_write_next;
            base_reg      <= base_next;
            len_reg       <= len_next;
            data_cnt_reg  <= data_cnt_next;
            pending_reg   <= pending_next;
            cursor_reg    <= cursor_next;
            range_err_reg <= range_err_next;
            sum_reg       <= sum_next;
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == CLR_LAST)
                    clearing_reg <= 1'b0;
            end
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_reg <= s1_next;
        if (s1_adv)
            out_reg <= out_next;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

endmodule

>>> design/srfs_checker.sv
// ----------------------------------------------------------------------------
// srfs_checker: response channel checks
// Watches the response port of the framed register-space slave and is
// attached to the top level by the bind statement at the end of this file.
// ----------------------------------------------------------------------------
module srfs_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input srfs_pkg::rsp_t rsp_data
);

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("Stalled response transfer changed or dropped.");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.tx_last |-> rsp_data.tx_valid)
        else $error("Checksum byte flagged without a valid response byte.");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.frame_done |-> !rsp_data.tx_valid)
        else $error("Completed request reported together with a response byte.");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.tx_valid |-> (rsp_data.tx_byte == 8'd0) && !rsp_data.tx_last)
        else $error("Response fields set while no byte is carried.");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.status == srfs_pkg::ST_OK) ||
                      (rsp_data.status == srfs_pkg::ST_HUNT) ||
                      (rsp_data.status == srfs_pkg::ST_RANGE))
        else $error("Undefined status code on the response channel.");

endmodule

bind spi_register_space_frame_slave srfs_checker u_srfs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
